### hw/rtl/kbc_pkg.sv
package kbc_pkg;

	// word and field widths
	localparam int WORD_BITS   = 64;
	localparam int WORD_PORT_W = 64;
	localparam int COUNT_W     = 7;
	localparam int BASE_W      = 6;
	localparam int CODE_W      = 5;
	localparam int LETTER_W    = 7;
	localparam int KIND_W      = 3;

	// letter map geometry
	localparam int MAP_ENTRIES = 128;
	localparam int MAP_AW      = $clog2(MAP_ENTRIES);

	// stream packing
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 72;

	// config port
	localparam int             ADDR_W    = 3;
	localparam logic [ADDR_W-1:0] REG_BASE = 3'd0;
	localparam logic [BASE_W-1:0] BASE_RESET = 6'd5;
	localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ADDH   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CHOP   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DROP   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_FWD    = 3'd5;
	localparam logic [KIND_W-1:0] KIND_BACK   = 3'd6;
	localparam logic [KIND_W-1:0] KIND_MAP    = 3'd7;

	// request into the letter map
	typedef struct packed {
		logic              we;
		logic              re;
		logic [MAP_AW-1:0] addr;
		logic [CODE_W-1:0] wdata;
	} map_req_t;

endpackage

### hw/rtl/kbc_letter_map.sv
module kbc_letter_map (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kbc_pkg::map_req_t      req,
	output logic [kbc_pkg::CODE_W-1:0] rdata
);
	import kbc_pkg::*;

	logic [CODE_W-1:0] mem [MAP_ENTRIES];
	logic [MAP_ENTRIES-1:0] valid_q;
	logic [CODE_W-1:0] rdata_q;

	// storage, no reset
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
	end

	// per-entry valid bits, unwritten letters read as code zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.we) begin
			valid_q[req.addr] <= 1'b1;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= valid_q[req.addr] ? mem[req.addr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/kmer_base_code_register_unit.sv
// k-mer register packed as a base-n number with nonzero digits.
// input stream: s_tuser carries the item kind, s_tdata the letter, the map
// code and the load word. one result item leaves on the m_ stream per input
// item: the packed word, its digit count and the empty head-drop flag.
// the number base is set through the apb port (register 0, reset 5). the user
// must change it only while no item is in flight; the block does not enforce it.
// one item is worked at a time; s_tready is high only while idle.
// every kind ends with a power search over the digits, sharing one 64x6
// multiplier and one 71-bit subtractor. chop tail adds a restoring division,
// head drop adds a power search, a check state and a remainder, append adds
// an append state and add head a power search and an add-head state.
// the finished result sits in an output register; the next item is taken
// while it waits, and a new result waits for the register to drain.
// reset clears the word, the letter map valid bits and the output valid,
// and returns the base to 5.
module kmer_base_code_register_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// s_tdata: letter[6:0], code[11:7], load_value[75:12], zero pad
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [kbc_pkg::IN_DATA_W-1:0]  s_tdata,
	// s_tuser: kind[2:0]
	input  logic [kbc_pkg::KIND_W-1:0]     s_tuser,
	// m_tdata: word[63:0], digit_count[70:64], empty_error[71]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [kbc_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [kbc_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import kbc_pkg::*;

	localparam int STATE_W = 3;
	localparam logic [STATE_W-1:0] S_IDLE   = 3'd0;
	localparam logic [STATE_W-1:0] S_APPEND = 3'd1;
	localparam logic [STATE_W-1:0] S_SEARCH = 3'd2;
	localparam logic [STATE_W-1:0] S_ADDH   = 3'd3;
	localparam logic [STATE_W-1:0] S_DIV    = 3'd4;
	localparam logic [STATE_W-1:0] S_DROP   = 3'd5;
	localparam logic [STATE_W-1:0] S_MOD    = 3'd6;
	localparam logic [STATE_W-1:0] S_DONE   = 3'd7;

	localparam int PROD_W = WORD_BITS + BASE_W;
	localparam int SUB_W  = WORD_BITS + BASE_W + 1;
	localparam int CNT_W  = $clog2(WORD_BITS);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_BITS - 1);
	localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(BASE_W - 1);

	logic [STATE_W-1:0] state_q, state_d, ret_q, ret_d;
	logic [KIND_W-1:0]  kind_q;
	logic [WORD_BITS-1:0] w_q, unit_q, prev_q;
	logic [COUNT_W-1:0] n_q;
	logic               over_q;
	logic [BASE_W-1:0]  rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               err_q;
	logic [BASE_W-1:0]  base_q, b_eff;
	logic               m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic               accept, out_free, start_search, search_more;
	logic [LETTER_W-1:0] in_letter;
	logic [CODE_W-1:0]  in_code, code_q;
	logic [WORD_BITS-1:0] in_load;
	map_req_t           map_req;

	logic [WORD_BITS-1:0] mul_a;
	logic [BASE_W-1:0]  mul_b;
	logic [PROD_W-1:0]  prod;
	logic [SUB_W-1:0]   sub_a, sub_b, diff;
	logic               ge;
	logic [BASE_W:0]    div_t;

	// field unpacking
	assign in_letter = s_tdata[6:0];
	assign in_code   = s_tdata[11:7];
	assign in_load   = s_tdata[12 +: WORD_BITS];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// config register
	assign pready = 1'b1;
	assign prdata = (paddr == REG_BASE) ? {{(32 - BASE_W){1'b0}}, base_q} : 32'd0;
	assign b_eff  = (base_q < BASE_MIN) ? BASE_MIN : base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_BASE) begin
			base_q <= pwdata[BASE_W-1:0];
		end
	end

	// letter map, read at accept
	always_comb begin
		map_req.we    = accept && (s_tuser == KIND_MAP);
		map_req.re    = accept;
		map_req.addr  = MAP_AW'(in_letter);
		map_req.wdata = in_code;
	end

	kbc_letter_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (map_req),
		.rdata  (code_q)
	);

	// shared multiplier
	always_comb begin
		case (state_q)
			S_ADDH: begin
				mul_a = unit_q;
				mul_b = BASE_W'(code_q);
			end
			S_SEARCH: begin
				mul_a = unit_q;
				mul_b = b_eff;
			end
			default: begin
				mul_a = w_q;
				mul_b = b_eff;
			end
		endcase
	end
	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	// shared subtract and compare
	assign div_t = {rem_q, w_q[WORD_BITS-1]};
	always_comb begin
		case (state_q)
			S_DIV: begin
				sub_a = SUB_W'(div_t);
				sub_b = SUB_W'(b_eff);
			end
			S_MOD: begin
				sub_a = SUB_W'(w_q);
				sub_b = SUB_W'(prev_q) << cnt_q;
			end
			default: begin
				sub_a = SUB_W'(w_q);
				sub_b = SUB_W'(unit_q);
			end
		endcase
	end
	assign diff = sub_a - sub_b;
	assign ge   = !diff[SUB_W-1];

	assign search_more = !over_q && ge;

	// sequencer
	always_comb begin
		state_d = state_q;
		ret_d   = S_DONE;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (s_tuser)
						KIND_APPEND: state_d = S_APPEND;
						KIND_CHOP, KIND_BACK: state_d = S_DIV;
						default: state_d = S_SEARCH;
					endcase
					if (s_tuser == KIND_ADDH) begin
						ret_d = S_ADDH;
					end else if (s_tuser == KIND_DROP || s_tuser == KIND_FWD) begin
						ret_d = S_DROP;
					end
				end
			end
			S_APPEND, S_ADDH: state_d = S_SEARCH;
			S_SEARCH: begin
				if (!search_more) begin
					state_d = ret_q;
				end
			end
			S_DIV: begin
				if (cnt_q == '0) begin
					state_d = S_SEARCH;
				end
				if (kind_q == KIND_BACK) begin
					ret_d = S_ADDH;
				end
			end
			S_DROP: begin
				if (n_q != '0) begin
					state_d = S_MOD;
				end else begin
					state_d = (kind_q == KIND_FWD) ? S_APPEND : S_SEARCH;
				end
			end
			S_MOD: begin
				if (cnt_q == '0) begin
					state_d = (kind_q == KIND_FWD) ? S_APPEND : S_SEARCH;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign start_search = (state_d == S_SEARCH) && (state_q != S_SEARCH);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_DONE;
			w_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_search) begin
				ret_q <= ret_d;
			end
			// packed word updates
			case (state_q)
				S_IDLE: begin
					if (accept && s_tuser == KIND_LOAD) begin
						w_q <= in_load;
					end
				end
				S_APPEND: w_q <= prod[WORD_BITS-1:0] + WORD_BITS'(code_q);
				S_ADDH:   w_q <= w_q + prod[WORD_BITS-1:0];
				S_DIV:    w_q <= {w_q[WORD_BITS-2:0], ge};
				S_DROP: begin
					if (n_q == '0) begin
						w_q <= '0;
					end
				end
				S_MOD: begin
					if (ge) begin
						w_q <= diff[WORD_BITS-1:0];
					end
				end
				default: w_q <= w_q;
			endcase
			// output register
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			err_q  <= 1'b0;
		end
		// power search iteration
		if (start_search) begin
			unit_q <= WORD_BITS'(1);
			n_q    <= '0;
			over_q <= 1'b0;
		end else if (state_q == S_SEARCH && search_more) begin
			n_q    <= n_q + COUNT_W'(1);
			prev_q <= unit_q;
			over_q <= (prod[PROD_W-1:WORD_BITS] != '0);
			unit_q <= prod[WORD_BITS-1:0];
		end
		// iteration counters and division remainder
		case (state_q)
			S_IDLE: begin
				cnt_q <= DIV_LAST;
				rem_q <= '0;
			end
			S_DIV: begin
				cnt_q <= cnt_q - CNT_W'(1);
				rem_q <= ge ? diff[BASE_W-1:0] : div_t[BASE_W-1:0];
			end
			S_DROP: begin
				cnt_q <= MOD_LAST;
				if (n_q == '0) begin
					err_q <= 1'b1;
				end
			end
			S_MOD: cnt_q <= cnt_q - CNT_W'(1);
			default: cnt_q <= cnt_q;
		endcase
		if (state_q == S_DONE && out_free) begin
			m_tdata_q <= {err_q, n_q, WORD_PORT_W'(w_q)};
		end
	end

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> n_q <= COUNT_W'(WORD_BITS))
		else $error("digit count past word width");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && !m_tvalid_q |=> m_tvalid_q && state_q == S_IDLE)
		else $error("finished item not moved to output register");

	a_mod_only_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DROP && n_q == '0 |=> state_q != S_MOD)
		else $error("remainder started on an empty word");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import kbc_pkg::*;

	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int SETTLE_WAIT  = 250;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 120;
	localparam int ALPHA_MAX    = 8;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// ascii letters used by the directed tests
	localparam logic [LETTER_W-1:0] LTR_A       = 7'h41;
	localparam logic [LETTER_W-1:0] LTR_C       = 7'h43;
	localparam logic [LETTER_W-1:0] LTR_G       = 7'h47;
	localparam logic [LETTER_W-1:0] LTR_T       = 7'h54;
	localparam logic [LETTER_W-1:0] LTR_Z       = 7'h5A;
	localparam logic [LETTER_W-1:0] LTR_LOWER_A = 7'h61;
	localparam logic [LETTER_W-1:0] LTR_LOWER_B = 7'h62;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [LETTER_W-1:0] letter;
		logic [CODE_W-1:0]   code;
		logic [63:0]         load_value;
	} kmer_item_t;

	typedef struct packed {
		logic [63:0]        word;
		logic [COUNT_W-1:0] digit_count;
		logic               empty_error;
	} kmer_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [KIND_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	// predictor state
	logic [63:0]       pred_word;
	logic [CODE_W-1:0] code_map [MAP_ENTRIES];
	logic [BASE_W-1:0] cur_base;

	kmer_result_t expected_kmers [$];
	kmer_result_t got_kmer;
	kmer_result_t want_kmer;

	int  fail_count;
	int  items_sent;
	int  results_seen;
	int  base_writes;
	int  stall_left;
	int  cycles;
	bit  idling;

	logic [LETTER_W-1:0] alpha_letters [ALPHA_MAX];
	int                  alpha_n;

	kmer_base_code_register_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				expected_kmers.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [63:0] eff_base();
		return (cur_base < 6'd2) ? 64'd2 : {58'd0, cur_base};
	endfunction

	// smallest power of the base above w, wrapped; digits of w on the side
	function automatic logic [63:0] power_above(input logic [63:0] w,
		output logic [COUNT_W-1:0] digits);
		logic [63:0] b;
		logic [63:0] unit;
		logic        over;
		int          n;
		b = eff_base();
		unit = 64'd1;
		over = 1'b0;
		n = 0;
		while (!over && unit <= w) begin
			n++;
			if (unit > ALL_ONES / b)
				over = 1'b1;
			unit = unit * b;
		end
		digits = n[COUNT_W-1:0];
		return unit;
	endfunction

	function automatic logic [COUNT_W-1:0] digits_of(input logic [63:0] w);
		logic [COUNT_W-1:0] d;
		logic [63:0]        unused;
		unused = power_above(w, d);
		return d;
	endfunction

	function automatic logic [63:0] code_of(input logic [LETTER_W-1:0] letter);
		return {59'd0, code_map[letter]};
	endfunction

	function automatic void add_head(input logic [LETTER_W-1:0] letter);
		logic [COUNT_W-1:0] d;
		logic [63:0]        unit;
		unit = power_above(pred_word, d);
		pred_word = pred_word + unit * code_of(letter);
	endfunction

	// head drop; returns 1 on an empty word
	function automatic logic drop_head();
		logic [COUNT_W-1:0] d;
		logic [63:0]        unit;
		logic [63:0]        unused;
		unused = power_above(pred_word, d);
		if (d == 0) begin
			pred_word = 64'd0;
			return 1'b1;
		end
		unit = 64'd1;
		while (d > 1) begin
			unit = unit * eff_base();
			d--;
		end
		pred_word = pred_word % unit;
		return 1'b0;
	endfunction

	function automatic kmer_result_t apply_kmer_op(input kmer_item_t it);
		kmer_result_t r;
		logic         err;
		err = 1'b0;
		case (it.kind)
			KIND_LOAD: pred_word = it.load_value;
			KIND_APPEND: pred_word = pred_word * eff_base() + code_of(it.letter);
			KIND_ADDH: add_head(it.letter);
			KIND_CHOP: pred_word = pred_word / eff_base();
			KIND_DROP: err = drop_head();
			KIND_FWD: begin
				err = drop_head();
				pred_word = pred_word * eff_base() + code_of(it.letter);
			end
			KIND_BACK: begin
				pred_word = pred_word / eff_base();
				add_head(it.letter);
			end
			default: code_map[it.letter] = it.code;
		endcase
		r.word = pred_word;
		r.digit_count = digits_of(pred_word);
		r.empty_error = err;
		return r;
	endfunction

	// ---------------------------------------------------------------- result side

	task automatic report_fail(input string what, input logic [63:0] want,
		input logic [63:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
	endtask

	// result checker, also schedules the next receiver stall
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got_kmer.word = m_tdata[63:0];
			got_kmer.digit_count = m_tdata[70:64];
			got_kmer.empty_error = m_tdata[71];
			if (expected_kmers.size() == 0) begin
				report_fail("unexpected result word", 64'd0, got_kmer.word);
			end else begin
				want_kmer = expected_kmers.pop_front();
				if (got_kmer.word !== want_kmer.word)
					report_fail("word", want_kmer.word, got_kmer.word);
				if (got_kmer.digit_count !== want_kmer.digit_count)
					report_fail("digit_count", 64'(want_kmer.digit_count),
						64'(got_kmer.digit_count));
				if (got_kmer.empty_error !== want_kmer.empty_error)
					report_fail("empty_error", 64'(want_kmer.empty_error),
						64'(got_kmer.empty_error));
			end
			stall_left = idling ? $urandom_range(0, 8) : 0;
		end
	end

	// receiver ready
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- stimulus side

	function automatic kmer_item_t make_item(input logic [KIND_W-1:0] kind,
		input logic [LETTER_W-1:0] letter, input logic [CODE_W-1:0] code,
		input logic [63:0] load_value);
		kmer_item_t it;
		it.kind = kind;
		it.letter = letter;
		it.code = code;
		it.load_value = load_value;
		return it;
	endfunction

	// called and left just after a falling edge
	task automatic send_item(input kmer_item_t it);
		int gap;
		gap = idling ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.kind;
		s_tdata <= {4'd0, it.load_value, it.code, it.letter};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_kmers.push_back(apply_kmer_op(it));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_kmers.size() != 0) @(negedge clk);
	endtask

	// base register write, block idle
	task automatic write_base(input logic [BASE_W-1:0] value);
		wait_idle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= REG_BASE;
		pwdata <= {26'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_base = value;
		base_writes++;
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed_ops();
		logic [63:0] top_power;
		top_power = 64'd1;
		while (top_power <= ALL_ONES / 64'd5) top_power = top_power * 64'd5;
		// nucleotide map at the reset base
		send_item(make_item(KIND_MAP, LTR_A, 5'd1, 64'd0));
		send_item(make_item(KIND_MAP, LTR_C, 5'd2, 64'd0));
		send_item(make_item(KIND_MAP, LTR_G, 5'd3, 64'd0));
		send_item(make_item(KIND_MAP, LTR_T, 5'd4, 64'd0));
		// empty word: head drop flags, chop stays zero, forward flags then appends
		send_item(make_item(KIND_DROP, LTR_A, 5'd0, 64'd0));
		send_item(make_item(KIND_CHOP, LTR_A, 5'd0, 64'd0));
		send_item(make_item(KIND_FWD, LTR_C, 5'd0, 64'd0));
		send_item(make_item(KIND_APPEND, LTR_A, 5'd0, 64'd0));
		send_item(make_item(KIND_ADDH, LTR_G, 5'd0, 64'd0));
		send_item(make_item(KIND_BACK, LTR_T, 5'd0, 64'd0));
		send_item(make_item(KIND_CHOP, LTR_A, 5'd0, 64'd0));
		// full word: power search runs past the word width
		send_item(make_item(KIND_LOAD, LTR_A, 5'd0, ALL_ONES));
		send_item(make_item(KIND_DROP, LTR_A, 5'd0, 64'd0));
		send_item(make_item(KIND_LOAD, LTR_A, 5'd0, ALL_ONES));
		send_item(make_item(KIND_ADDH, LTR_C, 5'd0, 64'd0));
		send_item(make_item(KIND_APPEND, LTR_T, 5'd0, 64'd0));
		send_item(make_item(KIND_LOAD, LTR_A, 5'd0, 64'd0));
		// code above the base, and an unmapped letter
		send_item(make_item(KIND_MAP, 7'h7F, 5'h1F, 64'd0));
		send_item(make_item(KIND_APPEND, 7'h7F, 5'd0, 64'd0));
		send_item(make_item(KIND_ADDH, LTR_Z, 5'd0, 64'd0));
		// digit count boundary at the top power
		send_item(make_item(KIND_LOAD, LTR_A, 5'd0, top_power));
		send_item(make_item(KIND_LOAD, LTR_A, 5'd0, top_power - 64'd1));
		send_item(make_item(KIND_BACK, LTR_A, 5'd0, 64'd0));
		// single digit word drops to zero
		send_item(make_item(KIND_LOAD, LTR_A, 5'd0, 64'd1));
		send_item(make_item(KIND_DROP, LTR_A, 5'd0, 64'd0));
	endtask

	task automatic test_base_extremes();
		logic [BASE_W-1:0] b;
		for (int i = 0; i < 2; i++) begin
			b = (i == 0) ? 6'd2 : 6'd32;
			write_base(b);
			send_item(make_item(KIND_MAP, LTR_LOWER_A, 5'd1, 64'd0));
			send_item(make_item(KIND_MAP, LTR_LOWER_B, b == 6'd2 ? 5'd1 : 5'd31, 64'd0));
			send_item(make_item(KIND_LOAD, LTR_LOWER_A, 5'd0, ALL_ONES));
			send_item(make_item(KIND_BACK, LTR_LOWER_B, 5'd0, 64'd0));
			send_item(make_item(KIND_LOAD, LTR_LOWER_A, 5'd0, ALL_ONES));
			send_item(make_item(KIND_ADDH, LTR_LOWER_B, 5'd0, 64'd0));
			send_item(make_item(KIND_FWD, LTR_LOWER_B, 5'd0, 64'd0));
			send_item(make_item(KIND_APPEND, LTR_LOWER_A, 5'd0, 64'd0));
			send_item(make_item(KIND_CHOP, LTR_LOWER_A, 5'd0, 64'd0));
		end
	endtask

	task automatic test_random_traffic();
		logic [BASE_W-1:0]  b;
		logic [COUNT_W-1:0] target_len;
		logic [COUNT_W-1:0] cur_len;
		logic [KIND_W-1:0]  kind;
		logic [63:0]        wide;
		kmer_item_t         it;
		int                 pick;
		int                 roll;
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			if (phase == 0)
				b = 6'd32;
			else if (phase == 1)
				b = 6'd2;
			else if (phase == RAND_PHASES - 1)
				b = BASE_RESET;
			else
				b = 6'($urandom_range(2, 32));
			write_base(b);
			idling = ($urandom_range(0, 3) != 0);
			// alphabet with codes 1..min(base-1, ALPHA_MAX)
			alpha_n = (b - 1 < ALPHA_MAX) ? int'(b) - 1 : ALPHA_MAX;
			for (int i = 0; i < alpha_n; i++) begin
				alpha_letters[i] = 7'($urandom_range(0, 127));
				send_item(make_item(KIND_MAP, alpha_letters[i],
					5'((i % (int'(b) - 1)) + 1), 64'd0));
			end
			target_len = 7'($urandom_range(1, int'(digits_of(ALL_ONES))));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 39)
					idling = ($urandom_range(0, 3) != 0);
				wide = {$urandom, $urandom};
				roll = $urandom_range(0, 99);
				if (roll < 12) begin
					// noise over the whole field ranges
					it = make_item(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
						5'($urandom_range(0, 31)), wide);
				end else if (roll < 17) begin
					it = make_item(KIND_LOAD, alpha_letters[0], 5'd0,
						wide >> $urandom_range(0, 63));
				end else begin
					cur_len = digits_of(pred_word);
					pick = $urandom_range(0, 9);
					if (cur_len < target_len) begin
						if (pick < 5)
							kind = KIND_APPEND;
						else if (pick < 7)
							kind = KIND_ADDH;
						else if (pick == 7)
							kind = KIND_FWD;
						else if (pick == 8)
							kind = KIND_BACK;
						else
							kind = ($urandom_range(0, 1) != 0) ? KIND_CHOP : KIND_DROP;
					end else begin
						if (pick < 4)
							kind = KIND_FWD;
						else if (pick < 8)
							kind = KIND_BACK;
						else if (pick == 8)
							kind = KIND_CHOP;
						else
							kind = KIND_DROP;
					end
					it = make_item(kind, alpha_letters[$urandom_range(0, alpha_n - 1)],
						5'd0, 64'd0);
				end
				send_item(it);
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		items_sent = 0;
		results_seen = 0;
		base_writes = 0;
		stall_left = 0;
		cycles = 0;
		idling = 1'b1;
		pred_word = 64'd0;
		cur_base = BASE_RESET;
		for (int i = 0; i < MAP_ENTRIES; i++) code_map[i] = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_ops();
		test_base_extremes();
		test_random_traffic();

		wait_idle();
		repeat (SETTLE_WAIT) @(negedge clk);
		fail_count += expected_kmers.size();

		$display("sent %0d items, checked %0d results across %0d base settings",
			items_sent, results_seen, base_writes + 1);
		$display("covered all item kinds, bases 2 to 32, empty and full words, %0d failures",
			fail_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
